### hw/rtl/stq_pkg.sv
// Shared types, codes and constants of the sorted timeout queue.
`default_nettype none

package stq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 16;

   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned MS_PER_SEC  = 1000;
   localparam int unsigned US_PER_MS   = 1000;
   // floor(usecs * RECIP_MUL / 2^RECIP_SHIFT) undershoots usecs / 1000 by at most one
   localparam int unsigned RECIP_MUL   = 1048;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam logic [31:0] EMPTY_WAIT  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0]          deadline;
      logic [TAG_WIDTH-1:0] handler;
      logic [TAG_WIDTH-1:0] ctx;
      logic [TAG_WIDTH-1:0] user;
   } entry_type;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_POLL     = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_FIRED   = 2'd2,
      ST_NOT_DUE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WAIT,
      S_INS_STEP,
      S_CAN_STEP,
      S_POLL_CHK,
      S_POP_STEP,
      S_HEAD_RD,
      S_HEAD_CHK
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/stq_mem.sv
// Entry store of the timeout queue: one write port, one registered read port.
`default_nettype none

module stq_mem (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [stq_pkg::ADDR_W-1:0]  wr_addr,
   input  wire stq_pkg::entry_type          wr_data,
   input  wire logic [stq_pkg::ADDR_W-1:0]  rd_addr,
   output stq_pkg::entry_type               rd_data
);

   stq_pkg::entry_type mem_ff [stq_pkg::QUEUE_DEPTH];
   stq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/stq_deadline.sv
// Deadline unit: now + secs*1000 + usecs/1000 over four registered steps.
`default_nettype none

module stq_deadline (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] now_ms,
   input  wire logic [15:0] delay_secs,
   input  wire logic [19:0] delay_usecs,
   output logic             done,
   output logic [31:0]      deadline
);

   logic [3:0]  vld_ff;
   logic [31:0] now_ff;
   logic [19:0] usecs_ff;
   logic [30:0] prod_ff;
   logic [25:0] secs_ms_ff;
   logic [25:0] secs_ms2_ff;
   logic [10:0] quot_ff;
   logic [20:0] back_ff;
   logic [26:0] sum_ff;
   logic [31:0] deadline_ff;

   logic [19:0] rem;
   logic [10:0] quot_fix;

   // quotient estimate is low by at most one: fix with one compare
   assign rem      = usecs_ff - back_ff[19:0];
   assign quot_fix = quot_ff + 11'(rem >= 20'(stq_pkg::US_PER_MS));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         now_ff     <= now_ms;
         usecs_ff   <= delay_usecs;
         prod_ff    <= 31'(delay_usecs) * 31'(stq_pkg::RECIP_MUL);
         secs_ms_ff <= 26'(delay_secs) * 26'(stq_pkg::MS_PER_SEC);
      end
      quot_ff     <= prod_ff[stq_pkg::RECIP_SHIFT +: 11];
      back_ff     <= 21'(prod_ff[stq_pkg::RECIP_SHIFT +: 11]) * 21'(stq_pkg::US_PER_MS);
      secs_ms2_ff <= secs_ms_ff;
      sum_ff      <= 27'(secs_ms2_ff) + 27'(quot_fix);
      if (vld_ff[2]) begin
         deadline_ff <= now_ff + 32'(sum_ff);
      end
   end

   assign done     = vld_ff[3];
   assign deadline = deadline_ff;

endmodule

`default_nettype wire

### hw/rtl/sorted_timeout_queue.sv
// Top level of the sorted timeout queue: sequencer, shared comparator, result registers.
`default_nettype none

// Sorted timeout queue. Holds up to 16 timeouts ordered by wrap-aware
// millisecond deadline (a is before b when bit 31 of a - b is set). A command
// transfers when start is high and busy is low; busy then stays high until the
// result is out, and no new command is taken meanwhile. Every command gives
// exactly one result, shown for one cycle with rsp_strobe high; the receiver
// cannot stall it and must take it in that cycle. busy falls in the same cycle
// that rsp_strobe rises, so the next command may transfer right then.
// Steps from transfer to result:
//   register: deadline unit, then a walk that places the new entry and ripples
//             the later entries up one slot, then head reread
//   register on a full queue, poll on an empty queue, unused code: head reread
//   poll with the head not yet due: head check, then head reread
//   cancel:   a walk that compacts the survivors, then head reread; head reread alone on an empty queue
//   poll that fires: head check, a walk shifting the rest down one slot if any remain, head reread
// The entry store has a single port pair, so each walk moves one entry per
// cycle. One 32-bit subtractor serves every deadline test and the wait
// computation. The store needs no clearing after reset.
module sorted_timeout_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [15:0] req_delay_secs,
   input  wire logic [19:0] req_delay_usecs,
   input  wire logic [15:0] req_handler_tag,
   input  wire logic [15:0] req_context_tag,
   input  wire logic [15:0] req_user_tag,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_removed_count,
   output logic [15:0]      rsp_fired_handler,
   output logic [15:0]      rsp_fired_context,
   output logic [15:0]      rsp_fired_user,
   output logic [31:0]      rsp_wait_ms,
   output logic [4:0]       rsp_queue_count
);

   localparam int CW = stq_pkg::CNT_W;
   localparam int AW = stq_pkg::ADDR_W;
   localparam int TW = stq_pkg::TAG_WIDTH;

   // sequencer state and working registers
   stq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [CW-1:0]       removed_ff, removed_in;
   logic                ins_ff, ins_in;
   stq_pkg::entry_type  carry_ff, carry_in;
   stq_pkg::status_type status_ff, status_in;
   logic [31:0]         now_ff, now_in;
   logic [TW-1:0]       htag_ff, htag_in;
   logic [TW-1:0]       ctag_ff, ctag_in;
   logic [TW-1:0]       utag_ff, utag_in;
   logic [TW-1:0]       fh_ff, fh_in;
   logic [TW-1:0]       fc_ff, fc_in;
   logic [TW-1:0]       fu_ff, fu_in;

   // result registers
   logic                rsp_strobe_ff, rsp_strobe_in;
   stq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [4:0]          rsp_removed_ff, rsp_removed_in;
   logic [15:0]         rsp_fh_ff, rsp_fh_in;
   logic [15:0]         rsp_fc_ff, rsp_fc_in;
   logic [15:0]         rsp_fu_ff, rsp_fu_in;
   logic [31:0]         rsp_wait_ff, rsp_wait_in;
   logic [4:0]          rsp_count_ff, rsp_count_in;

   // store ports
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   stq_pkg::entry_type  wr_data;
   logic [AW-1:0]       rd_addr;
   stq_pkg::entry_type  rd_q;

   // shared comparator
   logic [31:0]         sub_a, sub_b, diff;
   logic                now_before_head;

   // deadline unit
   logic                dl_start;
   logic                dl_done;
   logic [31:0]         dl_deadline;

   logic [CW-1:0]       cur_next;
   logic [CW-1:0]       cur_prev;
   logic                tag_match;
   stq_pkg::entry_type  new_entry;

   stq_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   stq_deadline u_deadline (
      .clock       (clock),
      .reset       (reset),
      .start       (dl_start),
      .now_ms      (req_now_ms),
      .delay_secs  (req_delay_secs),
      .delay_usecs (req_delay_usecs),
      .done        (dl_done),
      .deadline    (dl_deadline)
   );

   assign busy = (state_ff != stq_pkg::S_IDLE);

   // start the deadline arithmetic on the transfer itself; a full queue stores
   // nothing, so leave the unit idle for it
   assign dl_start = start && !busy &&
                     (stq_pkg::op_type'(req_operation) == stq_pkg::OP_REGISTER) &&
                     (cnt_ff != CW'(stq_pkg::QUEUE_DEPTH));

   assign diff     = sub_a - sub_b;
   assign cur_next = cur_ff + CW'(1);
   assign cur_prev = cur_ff - CW'(1);

   // with diff = head - now: now is before head when now - head is negative
   assign now_before_head = (diff != '0) && (!diff[31] || (diff[30:0] == '0));

   assign tag_match = (rd_q.handler == htag_ff) && (rd_q.ctx == ctag_ff) &&
                      (rd_q.user == utag_ff);

   assign new_entry = '{deadline: dl_deadline, handler: htag_ff, ctx: ctag_ff,
                        user: utag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stq_pkg::S_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      keep_ff        <= keep_in;
      removed_ff     <= removed_in;
      ins_ff         <= ins_in;
      carry_ff       <= carry_in;
      status_ff      <= status_in;
      now_ff         <= now_in;
      htag_ff        <= htag_in;
      ctag_ff        <= ctag_in;
      utag_ff        <= utag_in;
      fh_ff          <= fh_in;
      fc_ff          <= fc_in;
      fu_ff          <= fu_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_fh_ff      <= rsp_fh_in;
      rsp_fc_ff      <= rsp_fc_in;
      rsp_fu_ff      <= rsp_fu_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      keep_in        = keep_ff;
      removed_in     = removed_ff;
      ins_in         = ins_ff;
      carry_in       = carry_ff;
      status_in      = status_ff;
      now_in         = now_ff;
      htag_in        = htag_ff;
      ctag_in        = ctag_ff;
      utag_in        = utag_ff;
      fh_in          = fh_ff;
      fc_in          = fc_ff;
      fu_in          = fu_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_fh_in      = rsp_fh_ff;
      rsp_fc_in      = rsp_fc_ff;
      rsp_fu_in      = rsp_fu_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff[AW-1:0];
      wr_data        = rd_q;
      rd_addr        = '0;
      sub_a          = now_ff;
      sub_b          = rd_q.deadline;

      case (state_ff)
         stq_pkg::S_IDLE: begin
            if (start) begin
               // capture the command; the store reads the head right away
               now_in     = req_now_ms;
               htag_in    = TW'(req_handler_tag);
               ctag_in    = TW'(req_context_tag);
               utag_in    = TW'(req_user_tag);
               removed_in = '0;
               fh_in      = '0;
               fc_in      = '0;
               fu_in      = '0;
               status_in  = stq_pkg::ST_DONE;
               cur_in     = '0;
               keep_in    = '0;
               ins_in     = 1'b0;
               case (stq_pkg::op_type'(req_operation))
                  stq_pkg::OP_REGISTER: begin
                     if (cnt_ff == CW'(stq_pkg::QUEUE_DEPTH)) begin
                        status_in = stq_pkg::ST_FULL;
                        state_in  = stq_pkg::S_HEAD_RD;
                     end else begin
                        state_in = stq_pkg::S_INS_WAIT;
                     end
                  end
                  stq_pkg::OP_CANCEL: begin
                     state_in = (cnt_ff == '0) ? stq_pkg::S_HEAD_RD : stq_pkg::S_CAN_STEP;
                  end
                  stq_pkg::OP_POLL: begin
                     if (cnt_ff == '0) begin
                        status_in = stq_pkg::ST_NOT_DUE;
                        state_in  = stq_pkg::S_HEAD_RD;
                     end else begin
                        state_in = stq_pkg::S_POLL_CHK;
                     end
                  end
                  default: begin
                     state_in = stq_pkg::S_HEAD_RD;
                  end
               endcase
            end
         end

         stq_pkg::S_INS_WAIT: begin
            // keep entry 0 on the read port until the deadline is ready
            if (dl_done) begin
               state_in = stq_pkg::S_INS_STEP;
            end
         end

         stq_pkg::S_INS_STEP: begin
            // rd_q holds entry cur; place the new one before the first later
            // entry, then ripple the rest up one slot while reading ahead
            sub_a   = dl_deadline;
            rd_addr = cur_next[AW-1:0];
            if (!ins_ff && ((cur_ff == cnt_ff) || diff[31])) begin
               wr_en    = 1'b1;
               wr_data  = new_entry;
               ins_in   = 1'b1;
               carry_in = rd_q;
            end else if (ins_ff) begin
               wr_en    = 1'b1;
               wr_data  = carry_ff;
               carry_in = rd_q;
            end
            if (cur_ff == cnt_ff) begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = stq_pkg::S_HEAD_RD;
            end else begin
               cur_in = cur_next;
            end
         end

         stq_pkg::S_CAN_STEP: begin
            // drop matching entries, compact the survivors down to keep
            rd_addr = cur_next[AW-1:0];
            wr_addr = keep_ff[AW-1:0];
            if (tag_match) begin
               removed_in = removed_ff + CW'(1);
            end else begin
               wr_en   = 1'b1;
               keep_in = keep_ff + CW'(1);
            end
            if (cur_ff == cnt_ff - CW'(1)) begin
               cnt_in   = tag_match ? keep_ff : keep_ff + CW'(1);
               state_in = stq_pkg::S_HEAD_RD;
            end else begin
               cur_in = cur_next;
            end
         end

         stq_pkg::S_POLL_CHK: begin
            // rd_q holds the head; fire it unless now is still before it
            rd_addr = AW'(1);
            cur_in  = CW'(1);
            if (diff[31]) begin
               status_in = stq_pkg::ST_NOT_DUE;
               state_in  = stq_pkg::S_HEAD_RD;
            end else begin
               status_in = stq_pkg::ST_FIRED;
               fh_in     = rd_q.handler;
               fc_in     = rd_q.ctx;
               fu_in     = rd_q.user;
               if (cnt_ff == CW'(1)) begin
                  cnt_in   = '0;
                  state_in = stq_pkg::S_HEAD_RD;
               end else begin
                  state_in = stq_pkg::S_POP_STEP;
               end
            end
         end

         stq_pkg::S_POP_STEP: begin
            // shift entry cur down one slot
            wr_en   = 1'b1;
            wr_addr = cur_prev[AW-1:0];
            rd_addr = cur_next[AW-1:0];
            if (cur_ff == cnt_ff - CW'(1)) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = stq_pkg::S_HEAD_RD;
            end else begin
               cur_in = cur_next;
            end
         end

         stq_pkg::S_HEAD_RD: begin
            state_in = stq_pkg::S_HEAD_CHK;
         end

         stq_pkg::S_HEAD_CHK: begin
            // work out the time until the new head is due and present the result
            sub_a = rd_q.deadline;
            sub_b = now_ff;
            if (cnt_ff == '0) begin
               rsp_wait_in = stq_pkg::EMPTY_WAIT;
            end else if (now_before_head) begin
               rsp_wait_in = diff;
            end else begin
               rsp_wait_in = '0;
            end
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = status_ff;
            rsp_removed_in = 5'(removed_ff);
            rsp_fh_in      = 16'(fh_ff);
            rsp_fc_in      = 16'(fc_ff);
            rsp_fu_in      = 16'(fu_ff);
            rsp_count_in   = 5'(cnt_ff);
            state_in       = stq_pkg::S_IDLE;
         end

         default: begin
            state_in = stq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_fired_handler = rsp_fh_ff;
   assign rsp_fired_context = rsp_fc_ff;
   assign rsp_fired_user    = rsp_fu_ff;
   assign rsp_wait_ms       = rsp_wait_ff;
   assign rsp_queue_count   = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(stq_pkg::QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not raise busy");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stq_pkg::S_IDLE) |-> !wr_en)
      else $error("store written while idle");

   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(state_ff == stq_pkg::S_HEAD_CHK))
      else $error("result strobe outside the end of a command");

   a_fire_pops: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == stq_pkg::ST_FIRED)) |-> rsp_removed_count == '0)
      else $error("poll reported removed entries");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the sorted timeout queue: directed and random command streams.
`timescale 1ns / 100ps

module testbench;
   import stq_pkg::*;

   // One response as the queue should report it.
   typedef struct {
      status_type  status;
      logic [4:0]  removed;
      logic [15:0] handler;
      logic [15:0] ctx;
      logic [15:0] user;
      logic [31:0] wait_ms;
      logic [4:0]  count;
   } outcome_type;

   // Shadow copy of the timeout queue plus the responses still owed by the block.
   class timeout_shadow;
      logic [31:0] deadline [QUEUE_DEPTH];
      logic [15:0] handler [QUEUE_DEPTH];
      logic [15:0] ctx [QUEUE_DEPTH];
      logic [15:0] user [QUEUE_DEPTH];
      int unsigned held;
      outcome_type due_outcomes [$];
      int unsigned mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      // Wrap-aware ordering: a is earlier than b when bit 31 of a - b is set.
      function bit earlier(logic [31:0] a, logic [31:0] b);
         logic [31:0] diff;
         diff = a - b;
         return diff[31];
      endfunction

      function void move_entry(int unsigned dst, int unsigned src);
         deadline[dst] = deadline[src];
         handler[dst]  = handler[src];
         ctx[dst]      = ctx[src];
         user[dst]     = user[src];
      endfunction

      // Apply one accepted command to the shadow and queue up its response.
      function void note_command(op_type op, logic [31:0] now, logic [15:0] secs,
                                 logic [19:0] usecs, logic [15:0] h, logic [15:0] c,
                                 logic [15:0] u);
         outcome_type r;
         logic [31:0] due;
         int unsigned slot;
         int unsigned keep;
         int unsigned dropped;
         r.status  = ST_DONE;
         r.handler = '0;
         r.ctx     = '0;
         r.user    = '0;
         dropped   = 0;
         case (op)
            OP_REGISTER: begin
               if (held >= QUEUE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  due = now + 32'(secs) * MS_PER_SEC + 32'(usecs) / US_PER_MS;
                  // go after every entry that is not later
                  slot = held;
                  for (int i = 0; i < held; i++) begin
                     if (earlier(due, deadline[i])) begin
                        slot = i;
                        break;
                     end
                  end
                  for (int i = held; i > slot; i--) move_entry(i, i - 1);
                  deadline[slot] = due;
                  handler[slot]  = h;
                  ctx[slot]      = c;
                  user[slot]     = u;
                  held++;
               end
            end
            OP_CANCEL: begin
               keep = 0;
               for (int i = 0; i < held; i++) begin
                  if (handler[i] == h && ctx[i] == c && user[i] == u) begin
                     dropped++;
                  end else begin
                     if (keep != i) move_entry(keep, i);
                     keep++;
                  end
               end
               held = keep;
            end
            OP_POLL: begin
               if (held > 0 && !earlier(now, deadline[0])) begin
                  r.status  = ST_FIRED;
                  r.handler = handler[0];
                  r.ctx     = ctx[0];
                  r.user    = user[0];
                  for (int i = 1; i < held; i++) move_entry(i - 1, i);
                  held--;
               end else begin
                  r.status = ST_NOT_DUE;
               end
            end
            default: ;
         endcase
         if (held == 0)
            r.wait_ms = EMPTY_WAIT;
         else if (earlier(now, deadline[0]))
            r.wait_ms = deadline[0] - now;
         else
            r.wait_ms = '0;
         r.removed = 5'(dropped);
         r.count   = 5'(held);
         due_outcomes.push_back(r);
      endfunction

      // Compare one strobed response against the oldest owed one.
      function void check_response(logic [1:0] st, logic [4:0] removed, logic [15:0] h,
                                   logic [15:0] c, logic [15:0] u, logic [31:0] wait_ms,
                                   logic [4:0] count);
         outcome_type e;
         if (due_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with none owed: status %0d removed %0d count %0d",
                        st, removed, count);
            return;
         end
         e = due_outcomes.pop_front();
         if (st !== e.status || removed !== e.removed || h !== e.handler ||
             c !== e.ctx || u !== e.user || wait_ms !== e.wait_ms || count !== e.count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected status %0d removed %0d tags %h/%h/%h wait %h count %0d",
                        e.status, e.removed, e.handler, e.ctx, e.user, e.wait_ms, e.count);
               $display("          actual   status %0d removed %0d tags %h/%h/%h wait %h count %0d",
                        st, removed, h, c, u, wait_ms, count);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_delay_secs = '0;
   logic [19:0] req_delay_usecs = '0;
   logic [15:0] req_handler_tag = '0;
   logic [15:0] req_context_tag = '0;
   logic [15:0] req_user_tag = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_removed_count;
   logic [15:0] rsp_fired_handler;
   logic [15:0] rsp_fired_context;
   logic [15:0] rsp_fired_user;
   logic [31:0] rsp_wait_ms;
   logic [4:0]  rsp_queue_count;

   timeout_shadow shadow = new();

   // Skip all idle gaps while set, so back-to-back transfers get exercised.
   bit quiet = 1'b0;

   sorted_timeout_queue dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_now_ms        (req_now_ms),
      .req_delay_secs    (req_delay_secs),
      .req_delay_usecs   (req_delay_usecs),
      .req_handler_tag   (req_handler_tag),
      .req_context_tag   (req_context_tag),
      .req_user_tag      (req_user_tag),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_context (rsp_fired_context),
      .rsp_fired_user    (rsp_fired_user),
      .rsp_wait_ms       (rsp_wait_ms),
      .rsp_queue_count   (rsp_queue_count)
   );

   always #2 clock = ~clock;

   // End the run with an error if the block hangs.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Catch every strobed response; the receiver cannot stall, so take each one as it comes.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         shadow.check_response(rsp_status, rsp_removed_count, rsp_fired_handler,
                               rsp_fired_context, rsp_fired_user, rsp_wait_ms,
                               rsp_queue_count);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Drop start and idle, or, given no gap, leave start high for the next transfer.
   task automatic pause(int unsigned n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one command, hold it until the transfer, then note it and take the gap, if any.
   task automatic issue(op_type op, logic [31:0] now, logic [15:0] secs, logic [19:0] usecs,
                        logic [15:0] h, logic [15:0] c, logic [15:0] u);
      req_operation   <= op;
      req_now_ms      <= now;
      req_delay_secs  <= secs;
      req_delay_usecs <= usecs;
      req_handler_tag <= h;
      req_context_tag <= c;
      req_user_tag    <= u;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      shadow.note_command(op, now, secs, usecs, h, c, u);
      pause(quiet ? 0 : pick_gap());
   endtask

   // Drop start and hold until every owed response has come back.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (shadow.due_outcomes.size() != 0);
   endtask

   initial begin
      logic [31:0] clock_ms;
      logic [15:0] secs;
      logic [19:0] usecs;
      logic [15:0] h;
      logic [15:0] c;
      logic [15:0] u;
      logic [31:0] now;
      op_type      op;
      int unsigned sent;
      int unsigned roll;
      int unsigned bias;
      int unsigned pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // empty queue: poll with nothing due, cancel with no match, unused code
      issue(OP_POLL, 32'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      issue(OP_CANCEL, 32'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      issue(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 20'd999999, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // largest delay on top of the largest time: deadline wraps
      issue(OP_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 20'd999999, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // sub-millisecond delay truncates to zero; 1000 us is one millisecond
      issue(OP_REGISTER, 32'h0, 16'h0, 20'd999, 16'h0, 16'h0, 16'h0);
      issue(OP_REGISTER, 32'h0, 16'h0, 20'd1000, 16'h1, 16'h2, 16'h3);
      // equal deadline lands behind the earlier one
      issue(OP_REGISTER, 32'h0, 16'h0, 20'd0, 16'h4, 16'h5, 16'h6);
      issue(OP_POLL, 32'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      issue(OP_POLL, 32'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      // head one millisecond away: not due, then due
      issue(OP_POLL, 32'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      issue(OP_POLL, 32'h1, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
      // two of three tags match: nothing removed; then the full match
      issue(OP_CANCEL, 32'h1, 16'h0, 20'h0, 16'hFFFF, 16'hFFFF, 16'h0);
      issue(OP_CANCEL, 32'h1, 16'h0, 20'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // fill the queue with one tag set, overflow it, then cancel every entry at once
      for (int i = 0; i < QUEUE_DEPTH; i++)
         issue(OP_REGISTER, 32'h8000_0000 + 32'(i) * 7, 16'(i),
               20'($urandom_range(0, 999999)), 16'hA5A5, 16'h5A5A, 16'h0);
      issue(OP_REGISTER, 32'h8000_1000, 16'h0, 20'h0, 16'h1234, 16'h5678, 16'h9ABC);
      issue(OP_CANCEL, 32'h8000_1000, 16'h0, 20'h0, 16'hA5A5, 16'h5A5A, 16'h0);

      // --- random part ---
      // Track a running clock so most commands see plausible time; tags come mostly
      // from a small pool so cancels find matches. Phases lean toward filling or
      // draining the queue, chosen at random.
      clock_ms = $urandom();
      sent = 0;
      bias = 1;
      while (sent < 600) begin
         if (sent % 50 == 0) begin
            bias  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            // now and then park the clock just short of the wrap
            if ($urandom_range(0, 3) == 0)
               clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
         end
         // at least once, hold the sender until the block has answered everything
         if (sent == 300)
            drain();

         roll = $urandom_range(0, 99);
         case (bias)
            0:       op = (roll < 60) ? OP_REGISTER : (roll < 70) ? OP_CANCEL :
                          (roll < 98) ? OP_POLL : OP_NOP;
            1:       op = (roll < 40) ? OP_REGISTER : (roll < 55) ? OP_CANCEL :
                          (roll < 97) ? OP_POLL : OP_NOP;
            default: op = (roll < 20) ? OP_REGISTER : (roll < 35) ? OP_CANCEL :
                          (roll < 97) ? OP_POLL : OP_NOP;
         endcase

         // advance time, sometimes by a lot
         clock_ms += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200000)
                                                  : $urandom_range(0, 400);
         now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;

         pick = $urandom_range(0, 3);
         h = 16'h1000 + 16'(pick);
         c = 16'h2000 + 16'(pick);
         u = 16'(pick);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            h = 16'($urandom());
            c = 16'($urandom());
            u = 16'($urandom());
         end else if (op == OP_CANCEL && roll < 30) begin
            // break one tag so the entry nearly matches
            case ($urandom_range(0, 2))
               0:       h = ~h;
               1:       c = ~c;
               default: u = ~u;
            endcase
         end

         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            secs  = '0;
            usecs = '0;
         end else if (roll < 15) begin
            secs  = 16'($urandom());
            usecs = 20'($urandom_range(0, 999999));
         end else begin
            secs  = 16'($urandom_range(0, 1));
            usecs = 20'($urandom_range(0, 999999));
         end

         issue(op, now, secs, usecs, h, c, u);
         if (op != OP_NOP)
            sent++;
      end

      // --- wind down ---
      quiet = 1'b0;
      start <= 1'b0;
      while (shadow.due_outcomes.size() != 0) @(posedge clock);
      // give a stray response time to show up
      repeat (40) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.due_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
